[src/adsr_pkg.sv]
// shared constants, types and helpers for the adsr envelope generator
package adsr_pkg;

  localparam int LEVEL_FRAC_BITS = 24;
  localparam int LEVEL_W         = LEVEL_FRAC_BITS + 1;
  localparam int POLE_W          = LEVEL_FRAC_BITS;
  localparam int PROD_W          = 2 * LEVEL_W;
  localparam int MAC_W           = PROD_W + 1;

  localparam int APB_DATA_W      = 32;
  localparam int APB_ADDR_W      = 4;

  localparam logic [LEVEL_W-1:0] LEVEL_ONE  = LEVEL_W'(64'd1 << LEVEL_FRAC_BITS);
  localparam logic [LEVEL_W-1:0] LEVEL_HALF = LEVEL_W'(64'd1 << (LEVEL_FRAC_BITS - 1));
  // envelope above this ends the attack (floor of 0.99 in fixed point)
  localparam logic [LEVEL_W-1:0] ATTACK_END =
    LEVEL_W'(((64'd1 << LEVEL_FRAC_BITS) * 64'd99) / 64'd100);

  localparam logic [POLE_W-1:0]  ATTACK_POLE_RST  = POLE_W'(24'd16771392);
  localparam logic [POLE_W-1:0]  DECAY_POLE_RST   = POLE_W'(24'd16773721);
  localparam logic [POLE_W-1:0]  RELEASE_POLE_RST = POLE_W'(24'd16776051);
  localparam logic [LEVEL_W-1:0] SUSTAIN_RST      = LEVEL_W'(25'd8388608);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_ATTACK  = 2'd1,
    PH_DECAY   = 2'd2,
    PH_RELEASE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    REG_ATTACK_POLE  = 2'd0,
    REG_DECAY_POLE   = 2'd1,
    REG_RELEASE_POLE = 2'd2,
    REG_SUSTAIN      = 2'd3
  } reg_idx_t;

  function automatic logic [LEVEL_W-1:0] sat_one(input logic [LEVEL_W-1:0] v);
    sat_one = (v > LEVEL_ONE) ? LEVEL_ONE : v;
  endfunction

endpackage

[src/adsr_ifs.sv]
// valid/ready channel interfaces for gate input and envelope result
interface adsr_in_if import adsr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] gate_level;

  modport source (output valid, output gate_level, input ready);
  modport sink   (input valid, input gate_level, output ready);
endinterface

interface adsr_out_if import adsr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] envelope;
  logic [1:0]         phase;

  modport source (output valid, output envelope, output phase, input ready);
  modport sink   (input valid, input envelope, input phase, output ready);
endinterface

[src/adsr_envelope_generator_unit.sv]
// top level of the one-pole exponential adsr envelope generator
// each gate sample passes the stage 1 registers and then the result register
// throughput: one gate sample per cycle, sustained, while the output is taken
// stage 1 forms gate * sustain and the gate edges; stage 2 holds the feedback loop of
// the pole filter (two parallel multiplies, an add and the attack-end compare)
// reset (synchronous, active low) clears phase, previous gate, envelope and pole
// and restores the default pole and sustain registers; no clearing pass
module adsr_envelope_generator_unit import adsr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  adsr_in_if.sink               in_chan,
  adsr_out_if.source            out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // configuration registers
  logic [POLE_W-1:0]  attack_pole_r;
  logic [POLE_W-1:0]  decay_pole_r;
  logic [POLE_W-1:0]  release_pole_r;
  logic [LEVEL_W-1:0] sustain_r;

  // stage 1 registers
  logic               s1_valid_r;
  logic [LEVEL_W-1:0] s1_gate_r;
  logic [LEVEL_W-1:0] s1_target_r;
  logic               s1_rise_r;
  logic               s1_fall_r;
  logic [LEVEL_W-1:0] prev_gate_r;

  // filter state
  phase_t             phase_r, phase_nxt;
  logic [POLE_W-1:0]  pole_r, pole_nxt;
  logic [LEVEL_W-1:0] env_r, env_nxt;

  // result register
  logic               out_valid_r;
  logic [LEVEL_W-1:0] out_env_r, out_env_nxt;
  phase_t             out_phase_r;

  logic               advance;
  logic               s1_load;
  logic               in_xfer;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  logic [LEVEL_W-1:0] gate_sat;
  logic [PROD_W-1:0]  tgt_prod;
  logic [MAC_W-1:0]   tgt_sum;

  phase_t             ph_trig;
  logic [POLE_W-1:0]  pole_trig;
  logic [LEVEL_W-1:0] coef_b;
  logic [LEVEL_W-1:0] filt_x;
  logic [PROD_W-1:0]  prod_b;
  logic [PROD_W-1:0]  prod_a;
  logic [MAC_W-1:0]   mac_sum;
  logic [LEVEL_W-1:0] mac_out;

  // ---------------------------------------------------------------------------
  // apb configuration port, always ready, one register per word
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_pole_r  <= ATTACK_POLE_RST;
      decay_pole_r   <= DECAY_POLE_RST;
      release_pole_r <= RELEASE_POLE_RST;
      sustain_r      <= SUSTAIN_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ATTACK_POLE:  attack_pole_r  <= pwdata[POLE_W-1:0];
        REG_DECAY_POLE:   decay_pole_r   <= pwdata[POLE_W-1:0];
        REG_RELEASE_POLE: release_pole_r <= pwdata[POLE_W-1:0];
        REG_SUSTAIN:      sustain_r      <= pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ATTACK_POLE:  prdata = APB_DATA_W'(attack_pole_r);
      REG_DECAY_POLE:   prdata = APB_DATA_W'(decay_pole_r);
      REG_RELEASE_POLE: prdata = APB_DATA_W'(release_pole_r);
      REG_SUSTAIN:      prdata = APB_DATA_W'(sustain_r);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // flow control: the result register moves when empty or taken, stage 1
  // refills whenever its item moves on
  // ---------------------------------------------------------------------------
  assign advance       = !out_valid_r || out_chan.ready;
  assign s1_load       = !s1_valid_r || advance;
  assign in_chan.ready = s1_load;
  assign in_xfer       = in_chan.valid && s1_load;

  // ---------------------------------------------------------------------------
  // stage 1: saturate the gate, detect edges, scale the gate by sustain
  // ---------------------------------------------------------------------------
  assign gate_sat = sat_one(in_chan.gate_level);
  assign tgt_prod = gate_sat * sat_one(sustain_r);
  // round half up, the product is at most one squared
  assign tgt_sum  = MAC_W'(tgt_prod) + MAC_W'(LEVEL_HALF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      prev_gate_r <= '0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= in_chan.valid;
      end
      if (in_xfer) begin
        prev_gate_r <= gate_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_gate_r   <= gate_sat;
      s1_target_r <= tgt_sum[LEVEL_FRAC_BITS +: LEVEL_W];
      s1_rise_r   <= prev_gate_r < gate_sat;
      s1_fall_r   <= prev_gate_r > gate_sat;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: phase update and the one-pole filter y' = (1 - a) * x + a * y
  // ---------------------------------------------------------------------------
  always_comb begin
    // a rising gate retriggers attack, except while decaying
    ph_trig   = phase_r;
    pole_trig = pole_r;
    if (s1_rise_r && phase_r != PH_DECAY) begin
      ph_trig   = PH_ATTACK;
      pole_trig = attack_pole_r;
    end else if (s1_fall_r) begin
      ph_trig   = PH_RELEASE;
      pole_trig = release_pole_r;
    end
  end

  // attack heads for the gate itself, decay and release for gate * sustain
  assign filt_x  = (ph_trig == PH_ATTACK) ? s1_gate_r : s1_target_r;
  assign coef_b  = LEVEL_ONE - LEVEL_W'(pole_trig);
  assign prod_b  = coef_b * filt_x;
  assign prod_a  = LEVEL_W'(pole_trig) * env_r;
  assign mac_sum = MAC_W'(prod_b) + MAC_W'(prod_a) + MAC_W'(LEVEL_HALF);
  assign mac_out = mac_sum[LEVEL_FRAC_BITS +: LEVEL_W];

  always_comb begin
    phase_nxt   = ph_trig;
    pole_nxt    = pole_trig;
    env_nxt     = env_r;
    out_env_nxt = '0;
    case (ph_trig)
      PH_IDLE: begin
        // envelope held, result reads zero
      end
      PH_ATTACK: begin
        env_nxt     = mac_out;
        out_env_nxt = mac_out;
        if (mac_out > ATTACK_END) begin
          phase_nxt = PH_DECAY;
          pole_nxt  = decay_pole_r;
        end
      end
      PH_DECAY, PH_RELEASE: begin
        env_nxt     = mac_out;
        out_env_nxt = mac_out;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      pole_r      <= '0;
      env_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        phase_r <= phase_nxt;
        pole_r  <= pole_nxt;
        env_r   <= env_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_env_r   <= out_env_nxt;
      out_phase_r <= phase_nxt;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.envelope = out_env_r;
  assign out_chan.phase    = out_phase_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_phase_r == PH_IDLE |-> out_env_r == '0)
    else $error("idle result carries a nonzero envelope");

  a_env_range: assert property (@(posedge clk) disable iff (!rst_n)
    env_r <= LEVEL_ONE)
    else $error("envelope state above one");

  a_attack_below_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_phase_r == PH_ATTACK |-> out_env_r <= ATTACK_END)
    else $error("attack result past the attack end without entering decay");

  a_no_return_idle: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_IDLE |=> phase_r != PH_IDLE)
    else $error("phase fell back to idle");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(advance && s1_valid_r) |=> $stable(env_r) && $stable(pole_r))
    else $error("filter state changed without an item moving");

endmodule
